### rtl/assert_macros.svh
// Assertion macros used by the top unit to check its own logic.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/ssdm_pkg.sv
// Shared types and constants for the suffix dictionary matcher.
// Depends on nothing; used by the interfaces and every module but ssdm_ram.
package ssdm_pkg;

    localparam int REQ_TYPE_W = 2;
    localparam int LETTER_W   = 5;
    localparam int STATUS_W   = 2;

    // Default sizes of the dictionary and the stream history
    localparam int DEF_MAX_NODES     = 1024;
    localparam int DEF_MAX_WORD_LEN  = 32;
    localparam int DEF_ALPHABET_SIZE = 26;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request type codes on the input channel
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_END    = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd2;

    // Status codes on the result channel
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

    // Decoded operation handed from the front to the back
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_END,
        OP_QUERY,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [LETTER_W-1:0] letter;
        logic                in_alpha;
    } cmd_t;

endpackage

### rtl/ssdm_req_if.sv
// Request channel: valid/ready handshake with request type and letter.
// Depends on ssdm_pkg.
interface ssdm_req_if;
    import ssdm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [LETTER_W-1:0]   letter;

    modport source (output valid, output req_type, output letter, input ready);
    modport sink   (input valid, input req_type, input letter, output ready);
endinterface

### rtl/ssdm_rsp_if.sv
// Result channel: valid/ready handshake with match flag and status.
// Depends on ssdm_pkg.
interface ssdm_rsp_if;
    import ssdm_pkg::*;

    logic                valid;
    logic                ready;
    logic                matched;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output matched, output status, input ready);
    modport sink   (input valid, input matched, input status, output ready);
endinterface

### rtl/ssdm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module ssdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/ssdm_front.sv
// Front end: accepts requests, decodes them and queues them for the back end.
// Depends on ssdm_pkg and ssdm_req_if.
module ssdm_front #(
    parameter int ALPHABET_SIZE = ssdm_pkg::DEF_ALPHABET_SIZE
) (
    input  logic            clk,
    input  logic            rst_n,
    ssdm_req_if.sink        req,
    input  logic            hold,
    output logic            cmd_valid,
    output ssdm_pkg::cmd_t  cmd,
    input  logic            cmd_ready
);
    import ssdm_pkg::*;

    localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             dec;
    logic             push;
    logic             pop;

    // Decode the incoming request
    always_comb
    begin
        dec.letter   = req.letter;
        dec.in_alpha = (32'(req.letter) < ALPHABET_SIZE);
        unique case (req.req_type)
            REQ_INSERT: dec.op = OP_INSERT;
            REQ_END:    dec.op = OP_END;
            REQ_QUERY:  dec.op = OP_QUERY;
            default:    dec.op = OP_NOP;
        endcase
    end

    // Accept while there is room and no clearing pass runs
    assign req.ready = (count_reg != CNT_W'(QUEUE_DEPTH)) && !hold;
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    // Advance the queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the decoded request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule

### rtl/ssdm_back.sv
// Back end: owns the trie tables and the history ring, runs loads and
// walks, and holds the result register. Depends on ssdm_pkg, ssdm_rsp_if
// and ssdm_ram.
module ssdm_back #(
    parameter int MAX_NODES     = ssdm_pkg::DEF_MAX_NODES,
    parameter int MAX_WORD_LEN  = ssdm_pkg::DEF_MAX_WORD_LEN,
    parameter int ALPHABET_SIZE = ssdm_pkg::DEF_ALPHABET_SIZE
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  ssdm_pkg::cmd_t  cmd,
    output logic            cmd_ready,
    output logic            clearing,
    ssdm_rsp_if.source      rsp
);
    import ssdm_pkg::*;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int USED_W      = $clog2(MAX_NODES + 1);
    localparam int DEPTH_W     = $clog2(MAX_WORD_LEN + 1);
    localparam int RING_W      = MAX_WORD_LEN > 1 ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CHILD_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_CHK,
        ST_QRY_STEP,
        ST_QRY_CHK,
        ST_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [CHILD_AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [USED_W-1:0]     nodes_used_reg, nodes_used_next;
    logic [NODE_W-1:0]     cursor_reg, cursor_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic                  failed_reg, failed_next;
    logic [RING_W-1:0]     head_reg, head_next;
    logic [DEPTH_W-1:0]    fill_reg, fill_next;
    logic [RING_W-1:0]     pos_reg, pos_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [LETTER_W-1:0]   code_reg, code_next;
    logic                  code_ok_reg, code_ok_next;
    logic [DEPTH_W-1:0]    steps_reg, steps_next;
    logic                  first_reg, first_next;
    logic [CHILD_AW-1:0]   slot_reg, slot_next;
    logic                  res_match_reg, res_match_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_match_reg, out_match_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                  child_we;
    logic [CHILD_AW-1:0]   child_waddr;
    logic [NODE_W-1:0]     child_wdata;
    logic [CHILD_AW-1:0]   child_raddr;
    logic [NODE_W-1:0]     child_rdata;
    logic                  flag_we;
    logic [NODE_W-1:0]     flag_waddr;
    logic                  flag_wdata;
    logic [NODE_W-1:0]     flag_raddr;
    logic                  flag_rdata;
    logic                  ring_we;
    logic [RING_W-1:0]     ring_waddr;
    logic [LETTER_W-1:0]   ring_wdata;
    logic [RING_W-1:0]     ring_raddr;
    logic [LETTER_W-1:0]   ring_rdata;
    logic                  out_load;

    // Table slot of a node's child for one letter
    function automatic logic [CHILD_AW-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                    input logic [LETTER_W-1:0] code);
        logic [CHILD_AW-1:0] base;
        base = CHILD_AW'(CHILD_AW'(node) * CHILD_AW'(ALPHABET_SIZE));
        return base + CHILD_AW'(code);
    endfunction

    function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] p);
        return (p == RING_W'(MAX_WORD_LEN - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RING_W-1:0] ring_dec(input logic [RING_W-1:0] p);
        return (p == '0) ? RING_W'(MAX_WORD_LEN - 1) : p - 1'b1;
    endfunction

    ssdm_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    ssdm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    ssdm_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_WORD_LEN)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign clearing    = (state_reg == ST_CLEAR);
    assign rsp.valid   = out_valid_reg;
    assign rsp.matched = out_match_reg;
    assign rsp.status  = out_status_reg;
    assign out_load    = (state_reg == ST_RESP) && (!out_valid_reg || rsp.ready);

    // Sequencer: clearing pass, loads, walks and result hand-off
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        nodes_used_next = nodes_used_reg;
        cursor_next     = cursor_reg;
        depth_next      = depth_reg;
        failed_next     = failed_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        node_next       = node_reg;
        code_next       = code_reg;
        code_ok_next    = code_ok_reg;
        steps_next      = steps_reg;
        first_next      = first_reg;
        slot_next       = slot_reg;
        res_match_next  = res_match_reg;
        res_status_next = res_status_reg;

        child_we    = 1'b0;
        child_waddr = slot_reg;
        child_wdata = nodes_used_reg[NODE_W-1:0];
        child_raddr = slot_of(node_reg, code_reg);
        flag_we     = 1'b0;
        flag_waddr  = cursor_reg;
        flag_wdata  = 1'b1;
        flag_raddr  = child_rdata;
        ring_we     = 1'b0;
        ring_waddr  = head_reg;
        ring_wdata  = cmd.letter;
        ring_raddr  = ring_dec(pos_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one child slot per cycle, and the end flags alongside
                child_we    = 1'b1;
                child_waddr = clr_idx_reg;
                child_wdata = '0;
                flag_we     = (32'(clr_idx_reg) < MAX_NODES);
                flag_waddr  = clr_idx_reg[NODE_W-1:0];
                flag_wdata  = 1'b0;
                if (clr_idx_reg == CHILD_AW'(CHILD_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                child_raddr = slot_of(cursor_reg, cmd.letter);
                if (cmd_valid)
                begin
                    res_match_next  = 1'b0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_RESP;
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            // Skip letters of a rejected word and foreign codes
                            priority if (failed_reg || !cmd.in_alpha)
                            begin
                                res_status_next = STATUS_OK;
                            end
                            else if (depth_reg == DEPTH_W'(MAX_WORD_LEN))
                            begin
                                failed_next     = 1'b1;
                                res_status_next = STATUS_LONG;
                            end
                            else
                            begin
                                slot_next  = slot_of(cursor_reg, cmd.letter);
                                state_next = ST_INS_CHK;
                            end
                        end
                        OP_END:
                        begin
                            flag_we     = !failed_reg;
                            cursor_next = '0;
                            depth_next  = '0;
                            failed_next = 1'b0;
                        end
                        OP_QUERY:
                        begin
                            // Push the letter into the ring and start the walk
                            ring_we      = 1'b1;
                            pos_next     = head_reg;
                            head_next    = ring_inc(head_reg);
                            if (fill_reg != DEPTH_W'(MAX_WORD_LEN))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            node_next    = '0;
                            code_next    = cmd.letter;
                            code_ok_next = cmd.in_alpha;
                            steps_next   = '0;
                            first_next   = 1'b1;
                            state_next   = ST_QRY_STEP;
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_INS_CHK:
            begin
                state_next = ST_RESP;
                priority if (child_rdata != '0)
                begin
                    cursor_next = child_rdata;
                    depth_next  = depth_reg + 1'b1;
                end
                else if (nodes_used_reg == USED_W'(MAX_NODES))
                begin
                    failed_next     = 1'b1;
                    res_status_next = STATUS_FULL;
                end
                else
                begin
                    // Allocate the next free node as the child
                    child_we        = 1'b1;
                    cursor_next     = nodes_used_reg[NODE_W-1:0];
                    nodes_used_next = nodes_used_reg + 1'b1;
                    depth_next      = depth_reg + 1'b1;
                end
            end

            ST_QRY_STEP:
            begin
                priority if (!first_reg && flag_rdata)
                begin
                    res_match_next = 1'b1;
                    state_next     = ST_RESP;
                end
                else if (steps_reg == fill_reg || !code_ok_reg)
                begin
                    res_match_next = 1'b0;
                    state_next     = ST_RESP;
                end
                else
                begin
                    // Read the child and fetch the next older letter
                    pos_next   = ring_dec(pos_reg);
                    state_next = ST_QRY_CHK;
                end
            end

            ST_QRY_CHK:
            begin
                if (child_rdata == '0 || 32'(child_rdata) >= MAX_NODES)
                begin
                    res_match_next = 1'b0;
                    state_next     = ST_RESP;
                end
                else
                begin
                    node_next    = child_rdata;
                    code_next    = ring_rdata;
                    code_ok_next = (32'(ring_rdata) < ALPHABET_SIZE);
                    steps_next   = steps_reg + 1'b1;
                    first_next   = 1'b0;
                    state_next   = ST_QRY_STEP;
                end
            end

            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: load a finished result, drop it once transferred
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_match_next  = out_match_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_match_next  = res_match_reg;
            out_status_next = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            nodes_used_reg <= USED_W'(1);
            cursor_reg     <= '0;
            depth_reg      <= '0;
            failed_reg     <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            node_reg       <= '0;
            code_reg       <= '0;
            code_ok_reg    <= 1'b0;
            steps_reg      <= '0;
            first_reg      <= 1'b1;
            slot_reg       <= '0;
            res_match_reg  <= 1'b0;
            res_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_match_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            nodes_used_reg <= nodes_used_next;
            cursor_reg     <= cursor_next;
            depth_reg      <= depth_next;
            failed_reg     <= failed_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            node_reg       <= node_next;
            code_reg       <= code_next;
            code_ok_reg    <= code_ok_next;
            steps_reg      <= steps_next;
            first_reg      <= first_next;
            slot_reg       <= slot_next;
            res_match_reg  <= res_match_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_match_reg  <= out_match_next;
            out_status_reg <= out_status_next;
        end
    end
endmodule

### rtl/stream_suffix_dictionary_matcher_unit.sv
// Suffix dictionary matcher. Words are loaded last letter first into a
// reversed trie (insert items, then an end item); each query letter enters a
// ring of the last MAX_WORD_LEN letters and one result tells whether a stored
// word ends there. Exactly one result per request. After reset a clearing
// pass zeroes the node table (MAX_NODES*ALPHABET_SIZE slots, 26624 at the
// defaults), one slot per cycle; req.ready stays low meanwhile. A request
// queue of two entries lets requests arrive while the back end works. A query
// walks the trie, reading the child table and then the end-flag table for
// every letter. Depends on ssdm_pkg, the channel interfaces, ssdm_front,
// ssdm_back and assert_macros.svh.
`include "assert_macros.svh"

module stream_suffix_dictionary_matcher_unit #(
    parameter int MAX_NODES     = ssdm_pkg::DEF_MAX_NODES,
    parameter int MAX_WORD_LEN  = ssdm_pkg::DEF_MAX_WORD_LEN,
    parameter int ALPHABET_SIZE = ssdm_pkg::DEF_ALPHABET_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,
    ssdm_req_if.sink    req,
    ssdm_rsp_if.source  rsp
);
    import ssdm_pkg::*;

    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;
    logic  clearing;

    // Accept and decode requests
    ssdm_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .hold      (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    // Execute loads and walks
    ssdm_back #(
        .MAX_NODES     (MAX_NODES),
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .clearing  (clearing),
        .rsp       (rsp)
    );

    // No request transfer while the table is being cleared
    `ASSERT_ALWAYS(a_no_req_in_clear, clk, rst_n, !(clearing && req.valid && req.ready))
    // The clearing pass runs once after reset and never again
    `ASSERT_NEXT(a_clear_once, clk, rst_n, !clearing, !clearing)
    // The back end is busy in the cycle after taking a command
    `ASSERT_NEXT(a_back_busy, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)
endmodule
